### rtl/core/iebm_pkg.sv
// Shared constants and types for the I2C memory byte master.
package iebm_pkg;

    // Address bits kept from the command's memory address (1 to 16).
    localparam int unsigned ADDR_BITS = 16;

    localparam logic [6:0] DEVICE_CODE_RST = 7'd80;
    localparam logic [3:0] BYTE_BITS       = 4'd8;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Byte slots of a transaction
    localparam logic [2:0] IDX_DEV     = 3'd0;
    localparam logic [2:0] IDX_ADDR_HI = 3'd1;
    localparam logic [2:0] IDX_ADDR_LO = 3'd2;
    localparam logic [2:0] IDX_LAST    = 3'd3;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_S0   = 5'd1,
        PH_S1   = 5'd2,
        PH_S2   = 5'd3,
        PH_S3   = 5'd4,
        PH_BL   = 5'd5,
        PH_BH   = 5'd6,
        PH_AL   = 5'd7,
        PH_AH   = 5'd8,
        PH_RL   = 5'd9,
        PH_RH   = 5'd10,
        PH_P1   = 5'd11,
        PH_P2   = 5'd12,
        PH_P3   = 5'd13
    } t_phase;

endpackage

### rtl/core/iebm_if.sv
// Request, result and configuration channel interfaces.
interface iebm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [15:0] byte_addr;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, cmd, byte_addr, write_data, sda_in, input ready);
    modport sink   (input valid, cmd, byte_addr, write_data, sda_in, output ready);
endinterface

interface iebm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_byte, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_byte, output ready);
endinterface

interface iebm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] device_code;

    modport source (output valid, device_code, input ready);
    modport sink   (input valid, device_code, output ready);
endinterface

### rtl/core/i2c_eeprom_byte_master.sv
// I2C byte-write / random-read master for a two-byte-address memory, one tick per request.
// A request passes through the input register, then the result register; one request is
//   accepted and one result delivered every cycle while results are taken (o_res.ready).
// The bus sequence itself advances one SCL half-phase per request; rate is set by the
//   single next-state step between the two registers.
// Reset (i_rst_n, synchronous, active low): idle phase, empty registers, device code 80.
module i2c_eeprom_byte_master
    import iebm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    iebm_cfg_if.sink    i_cfg,
    iebm_cmd_if.sink    i_cmd,
    iebm_res_if.source  o_res
);

    // Configuration register
    logic [6:0]           r_device_code;

    // Input register
    logic                 r_in_valid;
    logic [1:0]           r_in_cmd;
    logic [15:0]          r_in_addr;
    logic [7:0]           r_in_wdata;
    logic                 r_in_sda;

    // Bus sequencer state
    t_phase               r_phase, n_phase;
    logic [3:0]           r_bit_count, n_bit_count;
    logic [7:0]           r_shift, n_shift;
    logic [2:0]           r_byte_index, n_byte_index;
    logic [ADDR_BITS-1:0] r_held_addr, n_held_addr;
    logic [7:0]           r_held_wdata, n_held_wdata;
    logic                 r_is_read, n_is_read;
    logic [7:0]           r_received, n_received;

    // Result register
    logic                 r_out_valid;
    logic                 r_out_scl, r_out_lvl, r_out_drv, r_out_busy, r_out_done;
    logic [7:0]           r_out_rbyte;

    logic                 n_scl, n_lvl, n_drv, n_busy, n_done;
    logic                 w_out_free;
    logic                 w_adv;
    logic                 w_start;
    t_phase               w_phase;
    logic [3:0]           w_bc_inc;
    logic [2:0]           w_idx_inc;
    logic [7:0]           w_rx_shift;

    // Byte sent in each slot of the transaction
    function automatic logic [7:0] byte_for(
        input logic [2:0]           idx,
        input logic [6:0]           dev,
        input logic [ADDR_BITS-1:0] addr,
        input logic [7:0]           wdat,
        input logic                 rd
    );
        logic [15:0] addr_ext;
        addr_ext = 16'(addr);
        case (idx)
            IDX_DEV:     byte_for = {dev, 1'b0};
            IDX_ADDR_HI: byte_for = addr_ext[15:8];
            IDX_ADDR_LO: byte_for = addr_ext[7:0];
            IDX_LAST:    byte_for = rd ? {dev, 1'b1} : wdat;
            default:     byte_for = 8'h00;
        endcase
    endfunction

    // Handshakes: the result register frees when taken, the input register when it advances
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_cmd.ready = !r_in_valid || w_out_free;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_out_scl;
    assign o_res.sda_level = r_out_lvl;
    assign o_res.sda_drive = r_out_drv;
    assign o_res.busy_res  = r_out_busy;
    assign o_res.done_res  = r_out_done;
    assign o_res.read_byte = r_out_rbyte;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_code <= DEVICE_CODE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_device_code <= i_cfg.device_code;
        end
    end

    // Input register: hold the request until the sequencer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd   <= i_cmd.cmd;
            r_in_addr  <= i_cmd.byte_addr;
            r_in_wdata <= i_cmd.write_data;
            r_in_sda   <= i_cmd.sda_in;
        end
    end

    // Sequencer state: advance once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_byte_index <= '0;
            r_held_addr  <= '0;
            r_held_wdata <= '0;
            r_is_read    <= 1'b0;
            r_received   <= '0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_byte_index <= n_byte_index;
            r_held_addr  <= n_held_addr;
            r_held_wdata <= n_held_wdata;
            r_is_read    <= n_is_read;
            r_received   <= n_received;
        end
    end

    // Next state and line levels for the current half-phase
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_byte_index = r_byte_index;
        n_held_addr  = r_held_addr;
        n_held_wdata = r_held_wdata;
        n_is_read    = r_is_read;
        n_received   = r_received;
        n_scl        = 1'b1;
        n_lvl        = 1'b1;
        n_drv        = 1'b1;
        n_busy       = 1'b1;
        n_done       = 1'b0;

        // A command taken in idle drives the first start half-phase right away;
        // commands while busy and the unused code are plain ticks.
        w_start = (r_phase == PH_IDLE) && (r_in_cmd == CMD_WRITE || r_in_cmd == CMD_READ);
        w_phase = w_start ? PH_S1 : r_phase;
        if (w_start) begin
            n_held_addr  = r_in_addr[ADDR_BITS-1:0];
            n_held_wdata = r_in_wdata;
            n_is_read    = (r_in_cmd == CMD_READ);
            n_byte_index = IDX_DEV;
            n_bit_count  = '0;
        end

        w_bc_inc   = r_bit_count + 4'd1;
        w_idx_inc  = r_byte_index + 3'd1;
        w_rx_shift = {r_shift[6:0], r_in_sda};

        case (w_phase)
            PH_IDLE: begin
                n_busy = 1'b0;
            end
            PH_S0: begin
                n_scl   = 1'b0;
                n_phase = PH_S1;
            end
            PH_S1: begin
                n_phase = PH_S2;
            end
            PH_S2: begin
                n_lvl   = 1'b0;
                n_phase = PH_S3;
            end
            PH_S3: begin
                n_scl       = 1'b0;
                n_lvl       = 1'b0;
                n_shift     = byte_for(r_byte_index, r_device_code, r_held_addr,
                                       r_held_wdata, r_is_read);
                n_bit_count = '0;
                n_phase     = PH_BL;
            end
            PH_BL: begin
                n_scl   = 1'b0;
                n_lvl   = r_shift[7];
                n_phase = PH_BH;
            end
            PH_BH: begin
                n_lvl       = r_shift[7];
                n_shift     = {r_shift[6:0], 1'b0};
                n_bit_count = w_bc_inc;
                n_phase     = (w_bc_inc >= BYTE_BITS) ? PH_AL : PH_BL;
            end
            PH_AL: begin
                n_scl   = 1'b0;
                n_drv   = 1'b0;
                n_phase = PH_AH;
            end
            PH_AH: begin
                // Stall with SCL high until the slave pulls SDA low
                n_drv = 1'b0;
                if (!r_in_sda) begin
                    n_byte_index = w_idx_inc;
                    if (w_idx_inc < IDX_LAST || (w_idx_inc == IDX_LAST && !r_is_read)) begin
                        n_shift     = byte_for(w_idx_inc, r_device_code, r_held_addr,
                                               r_held_wdata, r_is_read);
                        n_bit_count = '0;
                        n_phase     = PH_BL;
                    end else if (w_idx_inc == IDX_LAST) begin
                        n_phase = PH_S0;        // repeated start before the read code
                    end else if (r_is_read) begin
                        n_shift     = '0;
                        n_bit_count = '0;
                        n_phase     = PH_RL;
                    end else begin
                        n_phase = PH_P1;
                    end
                end
            end
            PH_RL: begin
                n_scl   = 1'b0;
                n_drv   = 1'b0;
                n_phase = PH_RH;
            end
            PH_RH: begin
                // Sample while SCL is high
                n_drv       = 1'b0;
                n_shift     = w_rx_shift;
                n_bit_count = w_bc_inc;
                if (w_bc_inc >= BYTE_BITS) begin
                    n_received = w_rx_shift;
                    n_phase    = PH_P1;
                end else begin
                    n_phase = PH_RL;
                end
            end
            PH_P1: begin
                n_scl   = 1'b0;
                n_lvl   = 1'b0;
                n_phase = PH_P2;
            end
            PH_P2: begin
                n_lvl   = 1'b0;
                n_phase = PH_P3;
            end
            PH_P3: begin
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_busy  = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_scl   <= n_scl;
            r_out_lvl   <= n_lvl;
            r_out_drv   <= n_drv;
            r_out_busy  <= n_busy;
            r_out_done  <= n_done;
            r_out_rbyte <= n_received;
        end
    end

    // A stalled request is never dropped from the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid)
        else $error("request lost while result stalled");

    // A plain tick in idle gives a result that is not busy
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_phase == PH_IDLE && r_in_cmd != CMD_WRITE && r_in_cmd != CMD_READ
        |=> !r_out_busy)
        else $error("idle tick reported busy");

    // Stop completion and a released line only occur inside a transaction
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_done || !r_out_drv) |-> r_out_busy)
        else $error("done or released SDA outside a transaction");

    // A command accepted in idle drives the start half-phase
    a_start_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_start |=> r_out_scl && r_out_lvl && r_out_drv && r_phase == PH_S2)
        else $error("start half-phase wrong");

endmodule
